// ===== src/dkeq_pkg.sv =====
package dkeq_pkg;

  // Fixed field widths
  localparam int KEY_W      = 9;
  localparam int FILL_W     = 7;
  localparam int DEBOUNCE_W = 16;
  localparam int IDX_W      = 8;

  // Defaults for the top-level parameters
  localparam int DEF_QUEUE_DEPTH = 128;
  localparam int DEF_NUM_BUTTONS = 3;

  // Debounce setting after reset
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd5;

  // Request operations
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_EDGE = 2'd1,
    OP_READ = 2'd2,
    OP_RSVD = 2'd3
  } req_op_t;

endpackage

// ===== src/dkeq_ram.sv =====
module dkeq_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/debounced_key_event_queue.sv =====
// Debounced key event queue.
// Input channel (in_*): one request per accepted beat. in_tuser carries the
// operation (tick, edge on a button, read oldest event); in_tdata carries the
// button index and the current pin levels. Ticks and edges produce no result.
// Result channel (out_*): one beat per read request with the key code, the
// fill count after the read, and an empty flag in out_tuser.
// Configuration (cfg_*): APB port, register 0 at address 0 holds the debounce
// setting in ticks (reset value 5). pready is always high.
// Throughput: one request per cycle. A tick on which several buttons expire
// pushes one event per cycle through the single write port of the queue
// memory, so it holds in_tready low until the expiries beyond the first are
// pushed. A read result is registered in the output register in the cycle after
// the request is accepted.
// Reset clears the countdowns, the queue pointers and the output valid flag;
// the queue memory and the result data are not cleared. While out_tready is
// low and a result is held, in_tready is low as well and no request is taken.
module debounced_key_event_queue
  import dkeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] button_index, [4:2] pin_levels
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [8:0] key_code, [15:9] fill_count
  output logic        out_tuser,  // [0] was_empty
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  localparam logic CFG_REG_DEBOUNCE = 1'b0;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [DEBOUNCE_W-1:0] debounce_r;
  logic                  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_wr && cfg_paddr[2] == CFG_REG_DEBOUNCE) begin
      debounce_r <= cfg_pwdata[DEBOUNCE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_REG_DEBOUNCE) ?
                      32'(debounce_r) : 32'd0;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic [1:0]           in_op;
  logic [1:0]           in_btn;
  logic [IDX_W-1:0]     in_pins;
  logic                 in_acc;
  logic                 acc_tick;
  logic                 acc_edge;
  logic                 acc_read;
  logic [NUM_BUTTONS-1:0] pend_r;
  logic [NUM_BUTTONS-1:0] pend_nxt;
  logic                 out_tvalid_r;
  logic                 out_free;

  assign in_op   = in_tuser;
  assign in_btn  = in_tdata[1:0];
  assign in_pins = IDX_W'(in_tdata[4:2]);

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (pend_r == '0) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign acc_tick  = in_acc && (in_op == OP_TICK);
  assign acc_edge  = in_acc && (in_op == OP_EDGE);
  assign acc_read  = in_acc && (in_op == OP_READ);

  // ---------------------------------------------------------------------------
  // Countdowns
  // ---------------------------------------------------------------------------
  logic [DEBOUNCE_W-1:0]  cnt_r   [NUM_BUTTONS];
  logic [DEBOUNCE_W-1:0]  cnt_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] run_r;
  logic [NUM_BUTTONS-1:0] run_nxt;
  logic [NUM_BUTTONS-1:0] expire;
  logic [DEBOUNCE_W-1:0]  load_val;
  logic [DEBOUNCE_W-1:0]  dec;

  // A zero setting behaves as one tick
  assign load_val = (debounce_r == '0) ? DEBOUNCE_W'(1) : debounce_r;

  always_comb begin
    dec = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      run_nxt[i] = run_r[i];
      expire[i]  = 1'b0;
      dec        = (cnt_r[i] != '0) ? cnt_r[i] - 1'b1 : cnt_r[i];
      if (acc_tick && run_r[i]) begin
        cnt_nxt[i] = dec;
        if (dec == '0) begin
          run_nxt[i] = 1'b0;
          expire[i]  = 1'b1;
        end
      end
      if (acc_edge && int'(in_btn) == i) begin
        cnt_nxt[i] = load_val;
        run_nxt[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      run_r <= run_nxt;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Push selection: lowest expiring button first, the rest held pending
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]       pins_r;
  logic [IDX_W-1:0]       push_pins;
  logic [NUM_BUTTONS-1:0] push_mask;
  logic [IDX_W-1:0]       push_idx;
  logic                   push_found;
  logic [KEY_W-1:0]       push_code;

  assign push_mask = (pend_r != '0) ? pend_r : expire;
  assign push_pins = (pend_r != '0) ? pins_r : in_pins;

  always_comb begin
    push_idx   = '0;
    push_found = 1'b0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (push_mask[i]) begin
        push_idx   = IDX_W'(i);
        push_found = 1'b1;
      end
    end
    pend_nxt = push_mask;
    if (push_found) begin
      pend_nxt[push_idx[$clog2(NUM_BUTTONS+1)-1:0]] = 1'b0;
    end
  end

  assign push_code = {push_pins[push_idx[2:0]], push_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // Keep pin levels of the tick for the held pushes
  always_ff @(posedge clk) begin
    if (acc_tick) begin
      pins_r <= in_pins;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring pointers
  // ---------------------------------------------------------------------------
  logic [AW-1:0] wptr_r;
  logic [AW-1:0] wptr_nxt;
  logic [AW-1:0] rptr_r;
  logic [AW-1:0] rptr_nxt;
  logic [AW-1:0] wptr_inc;
  logic [AW-1:0] rptr_inc;
  logic          q_full;
  logic          q_empty;
  logic          push_en;
  logic          pop_en;

  assign wptr_inc = (wptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
  assign rptr_inc = (rptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
  assign q_full   = (wptr_inc == rptr_r);
  assign q_empty  = (wptr_r == rptr_r);

  // Drop a push into a full queue
  assign push_en  = push_found && !q_full;
  assign pop_en   = acc_read && !q_empty;
  assign wptr_nxt = push_en ? wptr_inc : wptr_r;
  assign rptr_nxt = pop_en ? rptr_inc : rptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Event store; the head entry is prefetched every cycle
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] ram_rdata;
  logic             byp_r;
  logic [KEY_W-1:0] byp_data_r;
  logic [KEY_W-1:0] head_code;

  dkeq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (push_en),
    .waddr (wptr_r),
    .wdata (push_code),
    .raddr (rptr_nxt),
    .rdata (ram_rdata)
  );

  // Forward a write that lands on the head being fetched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= push_en && (wptr_r == rptr_nxt);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= push_code;
  end

  assign head_code = byp_r ? byp_data_r : ram_rdata;

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [AW:0]       fill_diff;
  logic [KEY_W-1:0]  key_r;
  logic [FILL_W-1:0] fill_r;
  logic              empty_r;

  assign fill_diff = (wptr_r >= rptr_nxt) ?
                     {1'b0, wptr_r} - {1'b0, rptr_nxt} :
                     {1'b0, wptr_r} + (AW+1)'(QUEUE_DEPTH) - {1'b0, rptr_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (acc_read) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // Capture the result of a read request
  always_ff @(posedge clk) begin
    if (acc_read) begin
      key_r   <= q_empty ? '0 : head_code;
      empty_r <= q_empty;
      fill_r  <= FILL_W'(fill_diff);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {fill_r, key_r};
  assign out_tuser  = empty_r;

endmodule

// ===== dv/debounced_key_event_queue_tb.sv =====
module debounced_key_event_queue_tb
  import dkeq_pkg::*;
();

  localparam int QDEPTH      = DEF_QUEUE_DEPTH;
  localparam int NBTN        = DEF_NUM_BUTTONS;
  localparam int SETTLE      = 8;     // covers the output register and expiry pushes
  localparam int STALL_LIMIT = 2000;  // cycles without any handshake

  // register addresses
  localparam logic [2:0] ADDR_DEBOUNCE = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]  code;
    logic              empty;
    logic [FILL_W-1:0] fill;
  } key_res_t;

  typedef struct packed {
    req_op_t    op;
    logic [1:0] btn;
    logic [2:0] pins;
    logic       lit;
    key_res_t   res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [1:0] button_index, [4:2] pin_levels
  logic [1:0]  in_tuser;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [8:0] key_code, [15:9] fill_count
  logic        out_tuser;  // [0] was_empty
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // literal expectation riding along with the current request
  logic        row_lit;
  key_res_t    row_res;

  // debounce and queue state as seen from outside
  logic [DEBOUNCE_W-1:0] debounce_set;
  logic [DEBOUNCE_W-1:0] countdown_now [NBTN];
  logic                  armed_now [NBTN];
  logic [KEY_W-1:0]      key_fifo_model [$];
  key_res_t              expected_reads [$];

  int fail_count;
  int cfg_fail_count;
  int stall_left;
  int quiet_cycles;
  bit gaps_on;

  // directed requests: reset state, ignored requests, expiry of two buttons
  // in one tick, empty read, restart of a running countdown
  dir_row_t dir_rows [0:22] = '{
    '{OP_READ, 2'd0, 3'd0, 1'b1, '{9'h000, 1'b1, 7'd0}},
    '{OP_RSVD, 2'd3, 3'd7, 1'b0, '0},
    '{OP_EDGE, 2'd3, 3'd7, 1'b0, '0},
    '{OP_EDGE, 2'd0, 3'd0, 1'b0, '0},
    '{OP_EDGE, 2'd2, 3'd0, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd7, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd7, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd7, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd7, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd5, 1'b0, '0},
    '{OP_READ, 2'd0, 3'd0, 1'b1, '{9'h100, 1'b0, 7'd1}},
    '{OP_READ, 2'd0, 3'd0, 1'b1, '{9'h102, 1'b0, 7'd0}},
    '{OP_READ, 2'd0, 3'd0, 1'b1, '{9'h000, 1'b1, 7'd0}},
    '{OP_EDGE, 2'd1, 3'd0, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd0, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd0, 1'b0, '0},
    '{OP_EDGE, 2'd1, 3'd0, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd0, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd0, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd0, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd0, 1'b0, '0},
    '{OP_TICK, 2'd0, 3'd2, 1'b0, '0},
    '{OP_READ, 2'd0, 3'd0, 1'b0, '0}
  };

  debounced_key_event_queue i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the debounce and queue state by one request; return the read result.
  task automatic debounce_and_queue(input req_op_t op, input logic [1:0] btn,
                                    input logic [2:0] pins, output bit has_res,
                                    output key_res_t res);
    int i;
    has_res = 1'b0;
    res     = '0;
    case (op)
      OP_TICK: begin
        // expiries are pushed in button order; a full queue drops the push
        for (i = 0; i < NBTN; i++) begin
          if (armed_now[i]) begin
            if (countdown_now[i] != 0) countdown_now[i] = countdown_now[i] - 1'b1;
            if (countdown_now[i] == 0) begin
              armed_now[i] = 1'b0;
              if (key_fifo_model.size() < QDEPTH - 1)
                key_fifo_model.push_back({pins[i], i[7:0]});
            end
          end
        end
      end
      OP_EDGE: begin
        // a zero setting behaves as one tick
        if (btn < NBTN) begin
          countdown_now[btn] = (debounce_set == 0) ? 16'd1 : debounce_set;
          armed_now[btn]     = 1'b1;
        end
      end
      OP_READ: begin
        has_res = 1'b1;
        if (key_fifo_model.size() != 0) begin
          res.code  = key_fifo_model.pop_front();
          res.empty = 1'b0;
        end else begin
          res.empty = 1'b1;
        end
        res.fill = FILL_W'(key_fifo_model.size());
      end
      default: ;
    endcase
  endtask

  // Track accepted requests and check results against the oldest expectation.
  always @(posedge clk) begin
    bit       has_res;
    key_res_t res;
    key_res_t want;
    // clear the countdown model while reset is held
    if (!rst_n) begin
      for (int b = 0; b < NBTN; b++) begin
        countdown_now[b] = '0;
        armed_now[b]     = 1'b0;
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      debounce_and_queue(req_op_t'(in_tuser), in_tdata[1:0], in_tdata[4:2], has_res, res);
      if (has_res) expected_reads.push_back(row_lit ? row_res : res);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reads.size() == 0) begin
        $error("read result with no read request pending: %h/%b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = expected_reads.pop_front();
        if (out_tdata[8:0] !== want.code) begin
          $error("key_code: expected %h, got %h", want.code, out_tdata[8:0]);
          fail_count++;
        end
        if (out_tuser !== want.empty) begin
          $error("was_empty: expected %b, got %b", want.empty, out_tuser);
          fail_count++;
        end
        if (out_tdata[15:9] !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, out_tdata[15:9]);
          fail_count++;
        end
      end
    end
  end

  // Stall the result channel in short random bursts.
  always @(posedge clk) begin
    if (!gaps_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Abort when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until accepted; a random gap may come first.
  task automatic send_req(input req_op_t op, input logic [1:0] btn, input logic [2:0] pins,
                          input logic lit, input key_res_t res);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, pins, btn};
    row_lit   <= lit;
    row_res   <= res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid, wait for every pending read result, then let the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register, then read back the debounce setting.
  task automatic cfg_access(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == ADDR_DEBOUNCE) debounce_set = data[DEBOUNCE_W-1:0];
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_DEBOUNCE;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {16'h0000, debounce_set}) begin
      $error("debounce_ticks: expected %h, got %h", debounce_set, cfg_prdata);
      cfg_fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Random mix of ticks, edges and reads with a few ignored requests.
  task automatic run_random(input int count);
    int         k;
    int         pick;
    req_op_t    op;
    logic [1:0] btn;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)       op = OP_RSVD;
      else if (pick < 45) op = OP_TICK;
      else if (pick < 75) op = OP_EDGE;
      else                op = OP_READ;
      btn = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, NBTN - 1));
      send_req(op, btn, 3'($urandom_range(0, 7)), 1'b0, '0);
    end
  endtask

  initial begin
    int k;
    int b;
    gaps_on      = 1'b1;
    debounce_set = DEBOUNCE_RESET;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    row_lit     <= 1'b0;
    row_res     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests on the reset setting
    for (k = 0; k < $size(dir_rows); k++)
      send_req(dir_rows[k].op, dir_rows[k].btn, dir_rows[k].pins,
               dir_rows[k].lit, dir_rows[k].res);

    // zero setting expires on the next tick
    wait_idle();
    cfg_access(ADDR_DEBOUNCE, 32'd0);
    run_random(350);

    // unmapped write is ignored; then overfill the queue and drain it past empty
    wait_idle();
    cfg_access(ADDR_UNMAPPED, $urandom);
    cfg_access(ADDR_DEBOUNCE, 32'd1);
    for (k = 0; k < 140; k++) begin
      if (k % 10 == 0) begin
        for (b = 0; b < NBTN; b++) send_req(OP_EDGE, 2'(b), 3'd0, 1'b0, '0);
      end else begin
        send_req(OP_EDGE, 2'($urandom_range(0, NBTN - 1)), 3'd0, 1'b0, '0);
      end
      send_req(OP_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 1'b0, '0);
    end
    for (k = 0; k < 130; k++)
      send_req(OP_READ, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 1'b0, '0);

    // longest setting: nothing expires
    wait_idle();
    cfg_access(ADDR_DEBOUNCE, 32'hFFFF_FFFF);
    run_random(150);

    // short random setting
    wait_idle();
    cfg_access(ADDR_DEBOUNCE, $urandom_range(2, 8));
    run_random(500);

    // closing stretch with both sides running flat out
    wait_idle();
    gaps_on = 1'b0;
    cfg_access(ADDR_DEBOUNCE, 32'd3);
    run_random(300);
    wait_idle();

    if (fail_count == 0 && cfg_fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
